// ===== sv/gha_pkg.sv =====
// Shared types, codes and constants of the generational handle allocator.
`default_nettype none

package gha_pkg;

  // Default sizing of the slot table.
  localparam int unsigned MAX_SLOTS_DEF = 1024;
  localparam int unsigned GEN_BITS_DEF  = 32;

  // Fixed widths of the external fields.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned SLOT_W_P = 10;
  localparam int unsigned GEN_W_P  = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned LIVE_W   = 11;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_CHECK   = 3'd2,
    OP_LOOKUP  = 3'd3,
    OP_NEXT    = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  // Source of the generation reported with a handle.
  typedef enum logic [1:0] {
    GSEL_RD,
    GSEL_INC,
    GSEL_ONE
  } gsel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    pop;
    logic    take_pop;
    logic    claim;
    logic    gen_rd;
    logic    gen_inc;
    logic    push;
    logic    cur_inc;
    logic    res_set;
    status_t res_status;
    logic    res_handle;
    gsel_t   res_gsel;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic fc_zero;
    logic hwm_full;
    logic cur_lt_hwm;
    logic occupied;
    logic handle_ok;
    logic reuse_ok;
    logic gen_odd;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/gha_datapath.sv =====
// Datapath: generation table, free stack, counters and result registers.
`default_nettype none

module gha_datapath #(
  parameter int unsigned MAX_SLOTS = gha_pkg::MAX_SLOTS_DEF,
  parameter int unsigned GEN_BITS  = gha_pkg::GEN_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_data,
  input  wire logic [gha_pkg::OP_W-1:0]     in_operation,
  input  wire logic [gha_pkg::SLOT_W_P-1:0] in_slot_index,
  input  wire logic [gha_pkg::GEN_W_P-1:0]  in_generation,
  input  wire logic                        in_from_start,
  input  wire gha_pkg::cmd_t               cmd,
  output gha_pkg::sts_t                    sts,
  output logic [gha_pkg::STAT_W-1:0]       out_status,
  output logic [gha_pkg::SLOT_W_P-1:0]     out_result_slot,
  output logic [gha_pkg::GEN_W_P-1:0]      out_result_generation,
  output logic [gha_pkg::LIVE_W-1:0]       out_live_count
);

  localparam int unsigned SLOT_W = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned SCAN_W = (CNT_W > gha_pkg::LIVE_W) ? CNT_W : gha_pkg::LIVE_W;
  localparam int unsigned LIVE_X = SCAN_W;

  // Storage.
  logic [GEN_BITS-1:0] gen_mem [MAX_SLOTS];
  logic [SLOT_W-1:0]   stk_mem [MAX_SLOTS];

  // Control registers.
  logic [CNT_W-1:0] fc_r;
  logic [CNT_W-1:0] hwm_r;
  logic             reuse_r;

  // Per-transaction payload registers.
  gha_pkg::op_t          op_r;
  logic [GEN_BITS-1:0]   gen_r;
  logic [SCAN_W-1:0]     cur_r;
  logic [GEN_BITS-1:0]   gen_q_r;
  logic [SLOT_W-1:0]     stk_q_r;
  gha_pkg::status_t      res_status_r;
  logic [gha_pkg::SLOT_W_P-1:0] res_slot_r;
  logic [GEN_BITS-1:0]   res_gen_r;

  logic [SCAN_W-1:0]     slot_ext;
  logic [CNT_W-1:0]      fc_m1;
  logic [SLOT_W-1:0]     rd_addr;
  logic [GEN_BITS-1:0]   gen_sel;
  logic [GEN_BITS-1:0]   gen_plus1;
  logic [LIVE_X-1:0]     live_x;
  logic [gha_pkg::GEN_W_P-1:0] res_gen_ext;

  assign slot_ext  = SCAN_W'(in_slot_index);
  assign fc_m1     = fc_r - CNT_W'(1);
  assign rd_addr   = cmd.take_pop ? stk_q_r : cur_r[SLOT_W-1:0];
  assign gen_plus1 = gen_q_r + GEN_BITS'(1);
  assign live_x    = LIVE_X'(hwm_r) - LIVE_X'(fc_r);

  // Generation picked for a reported handle.
  always_comb begin
    case (cmd.res_gsel)
      gha_pkg::GSEL_RD:  gen_sel = gen_q_r;
      gha_pkg::GSEL_INC: gen_sel = gen_plus1;
      gha_pkg::GSEL_ONE: gen_sel = GEN_BITS'(1);
      default:           gen_sel = gen_q_r;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    sts.op         = op_r;
    sts.fc_zero    = (fc_r == '0);
    sts.hwm_full   = (hwm_r == CNT_W'(MAX_SLOTS));
    sts.cur_lt_hwm = (cur_r < SCAN_W'(hwm_r));
    sts.gen_odd    = gen_q_r[0];
    sts.occupied   = sts.cur_lt_hwm && gen_q_r[0];
    sts.handle_ok  = sts.occupied && (gen_q_r == gen_r);
    sts.reuse_ok   = reuse_r && (fc_r != CNT_W'(MAX_SLOTS));
  end

  // Counters and the reuse register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r    <= '0;
      hwm_r   <= '0;
      reuse_r <= 1'b1;
    end else begin
      if (cfg_valid) begin
        reuse_r <= cfg_data;
      end
      if (cmd.pop) begin
        fc_r <= fc_m1;
      end else if (cmd.push) begin
        fc_r <= fc_r + CNT_W'(1);
      end
      if (cmd.claim) begin
        hwm_r <= hwm_r + CNT_W'(1);
      end
    end
  end

  // Input capture and slot cursor.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= gha_pkg::op_t'(in_operation);
      gen_r <= in_generation[GEN_BITS-1:0];
      if (gha_pkg::op_t'(in_operation) == gha_pkg::OP_NEXT) begin
        cur_r <= in_from_start ? '0 : slot_ext + SCAN_W'(1);
      end else begin
        cur_r <= slot_ext;
      end
    end else if (cmd.take_pop) begin
      cur_r <= SCAN_W'(stk_q_r);
    end else if (cmd.claim) begin
      cur_r <= SCAN_W'(hwm_r);
    end else if (cmd.cur_inc) begin
      cur_r <= cur_r + SCAN_W'(1);
    end
  end

  // Generation table: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.claim) begin
      gen_mem[hwm_r[SLOT_W-1:0]] <= GEN_BITS'(1);
    end else if (cmd.gen_inc) begin
      gen_mem[cur_r[SLOT_W-1:0]] <= gen_plus1;
    end
    if (cmd.gen_rd) begin
      gen_q_r <= gen_mem[rd_addr];
    end
  end

  // Free stack: push at the fill level, pop from just below it.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_mem[fc_r[SLOT_W-1:0]] <= cur_r[SLOT_W-1:0];
    end
    if (cmd.pop) begin
      stk_q_r <= stk_mem[fc_m1[SLOT_W-1:0]];
    end
  end

  // Result staging, cleared to "none found" at each new transaction.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status_r <= gha_pkg::ST_NONE;
      res_slot_r   <= '0;
      res_gen_r    <= '0;
    end else if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_slot_r   <= cmd.res_handle ? cur_r[gha_pkg::SLOT_W_P-1:0] : '0;
      res_gen_r    <= cmd.res_handle ? gen_sel : '0;
    end
  end

  always_comb begin
    res_gen_ext                = '0;
    res_gen_ext[GEN_BITS-1:0]  = res_gen_r;
  end

  // Output register, loaded only when the result side can take it.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status            <= res_status_r;
      out_result_slot       <= res_slot_r;
      out_result_generation <= res_gen_ext;
      out_live_count        <= live_x[gha_pkg::LIVE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/gha_ctrl.sv =====
// Controller state machine that sequences each operation over the datapath.
`default_nettype none

module gha_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic [gha_pkg::OP_W-1:0] in_operation,
  output logic                         in_stall,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  input  wire gha_pkg::sts_t           sts,
  output gha_pkg::cmd_t                cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CRT,
    S_POPRD,
    S_CUPD,
    S_CLAIMED,
    S_GRD,
    S_EVAL,
    S_SCAN,
    S_SCHK,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;

  // Output register is free when empty or being taken this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = gha_pkg::ST_OK;
    cmd.res_gsel   = gha_pkg::GSEL_RD;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (gha_pkg::op_t'(in_operation))
            gha_pkg::OP_CREATE:  state_nxt = S_CRT;
            gha_pkg::OP_DESTROY: state_nxt = S_GRD;
            gha_pkg::OP_CHECK:   state_nxt = S_GRD;
            gha_pkg::OP_LOOKUP:  state_nxt = S_GRD;
            gha_pkg::OP_NEXT:    state_nxt = S_SCAN;
            default:             state_nxt = S_OUT;
          endcase
        end
      end
      S_CRT: begin
        if (!sts.fc_zero) begin
          cmd.pop   = 1'b1;
          state_nxt = S_POPRD;
        end else if (!sts.hwm_full) begin
          cmd.claim = 1'b1;
          state_nxt = S_CLAIMED;
        end else begin
          cmd.res_set    = 1'b1;
          cmd.res_status = gha_pkg::ST_FULL;
          state_nxt      = S_OUT;
        end
      end
      S_POPRD: begin
        cmd.take_pop = 1'b1;
        cmd.gen_rd   = 1'b1;
        state_nxt    = S_CUPD;
      end
      S_CUPD: begin
        cmd.gen_inc    = 1'b1;
        cmd.res_set    = 1'b1;
        cmd.res_handle = 1'b1;
        cmd.res_gsel   = gha_pkg::GSEL_INC;
        state_nxt      = S_OUT;
      end
      S_CLAIMED: begin
        cmd.res_set    = 1'b1;
        cmd.res_handle = 1'b1;
        cmd.res_gsel   = gha_pkg::GSEL_ONE;
        state_nxt      = S_OUT;
      end
      S_GRD: begin
        cmd.gen_rd = 1'b1;
        state_nxt  = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_OUT;
        case (sts.op)
          gha_pkg::OP_DESTROY: begin
            if (sts.handle_ok) begin
              cmd.push    = sts.reuse_ok;
              cmd.gen_inc = 1'b1;
              cmd.res_set = 1'b1;
            end
          end
          gha_pkg::OP_CHECK: begin
            cmd.res_set = sts.handle_ok;
          end
          gha_pkg::OP_LOOKUP: begin
            cmd.res_set    = sts.occupied;
            cmd.res_handle = 1'b1;
          end
          default: begin
            cmd.res_set = 1'b0;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.cur_lt_hwm) begin
          cmd.gen_rd = 1'b1;
          state_nxt  = S_SCHK;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SCHK: begin
        if (sts.gen_odd) begin
          cmd.res_set    = 1'b1;
          cmd.res_handle = 1'b1;
          state_nxt      = S_OUT;
        end else begin
          cmd.cur_inc = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and the result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/generational_handle_allocator_core.sv =====
// Handle allocator with one generation per slot: top level.
// One transaction is in flight at a time. Destroy, check and lookup read the generation
// and then evaluate it; create pops a freed slot and bumps its generation, claims a new
// slot, or reports table full; an unknown operation goes straight to the output; next
// occupied reads slots in turn until one is occupied or the high-water mark is reached.
// Reset clears the counters and sets slot reuse on; the tables are not cleared.
`default_nettype none

module generational_handle_allocator_core #(
  parameter int unsigned MAX_SLOTS = gha_pkg::MAX_SLOTS_DEF,
  parameter int unsigned GEN_BITS  = gha_pkg::GEN_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [gha_pkg::OP_W-1:0]     in_operation,
  input  wire logic [gha_pkg::SLOT_W_P-1:0] in_slot_index,
  input  wire logic [gha_pkg::GEN_W_P-1:0]  in_generation,
  input  wire logic                        in_from_start,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [gha_pkg::STAT_W-1:0]       out_status,
  output logic [gha_pkg::SLOT_W_P-1:0]     out_result_slot,
  output logic [gha_pkg::GEN_W_P-1:0]      out_result_generation,
  output logic [gha_pkg::LIVE_W-1:0]       out_live_count
);

  gha_pkg::cmd_t cmd;
  gha_pkg::sts_t sts;

  // The reuse register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  gha_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  gha_datapath #(
    .MAX_SLOTS (MAX_SLOTS),
    .GEN_BITS  (GEN_BITS)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_data              (cfg_data),
    .in_operation          (in_operation),
    .in_slot_index         (in_slot_index),
    .in_generation         (in_generation),
    .in_from_start         (in_from_start),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_status            (out_status),
    .out_result_slot       (out_result_slot),
    .out_result_generation (out_result_generation),
    .out_live_count        (out_live_count)
  );

endmodule

`default_nettype wire
